/* hw/rtl/assert_macros.svh */
// Assertion helpers shared by the RTL. With SYNTH defined they expand to nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Clocked property that is ignored while the active-low reset is asserted.
`define ASSERT_CLKD(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) prop) else $error(msg);
// Clocked property that is also checked during reset.
`define ASSERT_CLK(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CLKD(lbl, clk, rst_n, prop, msg)
`define ASSERT_CLK(lbl, clk, prop, msg)
`endif
`endif

/* hw/rtl/fac_pkg.sv */
`default_nettype none
package fac_pkg;

    localparam int FUNC_W   = 3;
    localparam int FRAME_W  = 6;
    localparam int OWNER_W  = 8;
    localparam int PAGE_W   = 16;
    localparam int STATUS_W = 2;

    localparam int NUM_FRAMES_DEF = 64;

    typedef logic [FUNC_W-1:0]   t_func;
    typedef logic [STATUS_W-1:0] t_status;

    localparam t_func FN_ALLOC   = 3'd0;
    localparam t_func FN_RELEASE = 3'd1;
    localparam t_func FN_UNLOCK  = 3'd2;
    localparam t_func FN_OWNER   = 3'd3;
    localparam t_func FN_TOUCH   = 3'd4;

    localparam t_status ST_OK    = 2'd0;
    localparam t_status ST_EVICT = 2'd1;
    localparam t_status ST_BUSY  = 2'd2;
    localparam t_status ST_ERR   = 2'd3;

endpackage
`default_nettype wire

/* hw/rtl/fac_req_if.sv */
`default_nettype none
interface fac_req_if;
    import fac_pkg::*;

    logic                valid;
    logic                ready;
    t_func               func;
    logic [FRAME_W-1:0]  frame;
    logic [OWNER_W-1:0]  owner_id;
    logic [PAGE_W-1:0]   virtual_page;
    logic                is_write;

    modport source (output valid, func, frame, owner_id, virtual_page, is_write,
                    input ready);
    modport sink   (input valid, func, frame, owner_id, virtual_page, is_write,
                    output ready);
endinterface
`default_nettype wire

/* hw/rtl/fac_rsp_if.sv */
`default_nettype none
interface fac_rsp_if;
    import fac_pkg::*;

    logic                valid;
    logic                ready;
    t_status             status;
    logic [FRAME_W-1:0]  result_frame;
    logic [OWNER_W-1:0]  old_owner;
    logic [PAGE_W-1:0]   old_page;
    logic                old_dirty;

    modport source (output valid, status, result_frame, old_owner, old_page, old_dirty,
                    input ready);
    modport sink   (input valid, status, result_frame, old_owner, old_page, old_dirty,
                    output ready);
endinterface
`default_nettype wire

/* hw/rtl/fac_ram.sv */
`default_nettype none
module fac_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                                    i_clk,
    input  wire logic                                    i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                        i_wdata,
    input  wire logic                                    i_re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

/* hw/rtl/frame_allocator_clock_replace.sv */
// Channel | Dir | Handshake     | Payload
// i_req   | in  | valid / ready | func, frame, owner_id, virtual_page, is_write
// o_rsp   | out | valid / ready | status, result_frame, old_owner, old_page, old_dirty
//
// Allocate from the free stack, release, unlock, change owner and touch go
// from transfer to result through a memory read, an update and an output load.
// An allocate that evicts examines one frame per cycle on the frame memory,
// up to 2*NUM_FRAMES frames in all.
// After reset a clearing pass over all NUM_FRAMES entries initializes the frame
// memory; no input transfer is taken until it is done.
// A new request is taken while the previous result waits; a stalled output
// holds the next result in the finish state until the slot frees.
`default_nettype none
`include "assert_macros.svh"
module frame_allocator_clock_replace #(
    parameter int NUM_FRAMES = fac_pkg::NUM_FRAMES_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    fac_req_if.sink    i_req,
    fac_rsp_if.source  o_rsp
);
    import fac_pkg::*;

    localparam int IW = $clog2(NUM_FRAMES);
    localparam int CW = $clog2(NUM_FRAMES + 1);
    localparam int NW = $clog2(2 * NUM_FRAMES);
    localparam int EW = 4 + OWNER_W + PAGE_W;

    localparam logic [IW-1:0] LAST_FRAME = IW'(NUM_FRAMES - 1);
    localparam logic [NW-1:0] LAST_STEP  = NW'(2 * NUM_FRAMES - 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(NUM_FRAMES);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_LOOK  = 3'd2;
    localparam logic [2:0] S_WALK  = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    // Per-frame record. alloc is the inverse of the free bit so that zero is the reset value.
    typedef struct packed {
        logic               alloc;
        logic               lock;
        logic               used;
        logic               dirty;
        logic [OWNER_W-1:0] owner;
        logic [PAGE_W-1:0]  page;
    } t_entry;

    typedef struct packed {
        t_status            status;
        logic [FRAME_W-1:0] frame;
        logic [OWNER_W-1:0] owner;
        logic [PAGE_W-1:0]  page;
        logic               dirty;
    } t_rsp;

    logic [2:0]         r_state, n_state;
    logic [IW-1:0]      r_clr, n_clr;
    logic [CW-1:0]      r_fc, n_fc;
    logic [CW-1:0]      r_deep, n_deep;
    logic [IW-1:0]      r_hand, n_hand;
    logic [IW-1:0]      r_pos, n_pos;
    logic [NW-1:0]      r_cnt, n_cnt;
    t_rsp               r_res, n_res;
    t_rsp               r_out, n_out;
    logic               r_o_valid, n_o_valid;

    t_func              r_func;
    logic [FRAME_W-1:0] r_frame;
    logic [OWNER_W-1:0] r_owner;
    logic [PAGE_W-1:0]  r_page;
    logic               r_wr;

    logic               st_we, st_re;
    logic [IW-1:0]      st_waddr, st_raddr;
    t_entry             st_wdata, st_rdata;
    logic               sk_we, sk_re;
    logic [IW-1:0]      sk_waddr, sk_raddr, sk_rdata;

    logic [CW-1:0]      top_c;
    logic [IW-1:0]      hand_next, pos_next, grant_idx;
    logic               in_range;
    t_entry             grant_entry;
    logic               xfer_in;

    function automatic logic [IW-1:0] r_frame_idx(input logic [FRAME_W-1:0] f);
        return IW'(f);
    endfunction

    fac_ram #(.WIDTH(EW), .DEPTH(NUM_FRAMES)) u_frame_ram (
        .i_clk   (i_clk),
        .i_we    (st_we),
        .i_waddr (st_waddr),
        .i_wdata (st_wdata),
        .i_re    (st_re),
        .i_raddr (st_raddr),
        .o_rdata (st_rdata)
    );

    fac_ram #(.WIDTH(IW), .DEPTH(NUM_FRAMES)) u_stack_ram (
        .i_clk   (i_clk),
        .i_we    (sk_we),
        .i_waddr (sk_waddr),
        .i_wdata (r_frame_idx(r_frame)),
        .i_re    (sk_re),
        .i_raddr (sk_raddr),
        .o_rdata (sk_rdata)
    );

    assign i_req.ready        = (r_state == S_IDLE);
    assign xfer_in            = i_req.valid && i_req.ready;
    assign o_rsp.valid        = r_o_valid;
    assign o_rsp.status       = r_out.status;
    assign o_rsp.result_frame = r_out.frame;
    assign o_rsp.old_owner    = r_out.owner;
    assign o_rsp.old_page     = r_out.page;
    assign o_rsp.old_dirty    = r_out.dirty;

    // The stack top sits at NUM_FRAMES - free count. Slots at or beyond the
    // deepest top ever reached were never written; the top index itself stands for them.
    assign top_c     = FULL_COUNT - r_fc;
    assign hand_next = (r_hand == LAST_FRAME) ? '0 : r_hand + 1'b1;
    assign pos_next  = (r_pos == LAST_FRAME) ? '0 : r_pos + 1'b1;
    assign grant_idx = (top_c == r_deep) ? IW'(top_c) : sk_rdata;
    assign in_range  = (32'(r_frame) < 32'(NUM_FRAMES));

    always_comb begin
        grant_entry       = '0;
        grant_entry.alloc = 1'b1;
        grant_entry.lock  = 1'b1;
        grant_entry.owner = r_owner;
        grant_entry.page  = r_page;
    end

    always_comb begin
        n_state   = r_state;
        n_clr     = r_clr;
        n_fc      = r_fc;
        n_deep    = r_deep;
        n_hand    = r_hand;
        n_pos     = r_pos;
        n_cnt     = r_cnt;
        n_res     = r_res;
        n_out     = r_out;
        n_o_valid = r_o_valid && !o_rsp.ready;
        st_we     = 1'b0;
        st_waddr  = r_pos;
        st_wdata  = st_rdata;
        st_re     = 1'b0;
        st_raddr  = r_frame_idx(i_req.frame);
        sk_we     = 1'b0;
        sk_waddr  = IW'(top_c - 1'b1);
        sk_re     = 1'b0;
        sk_raddr  = IW'(top_c);

        case (r_state)
            S_CLEAR: begin
                st_we    = 1'b1;
                st_waddr = r_clr;
                st_wdata = '0;
                n_clr    = r_clr + 1'b1;
                if (r_clr == LAST_FRAME) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_req.valid) begin
                    sk_re = 1'b1;
                    st_re = 1'b1;
                    if (i_req.func == FN_ALLOC && r_fc == '0) begin
                        st_raddr = hand_next;
                        n_pos    = hand_next;
                        n_cnt    = '0;
                        n_state  = S_WALK;
                    end else begin
                        n_state = S_LOOK;
                    end
                end
            end
            S_LOOK: begin
                n_state = S_DONE;
                n_res   = '0;
                if (r_func == FN_ALLOC) begin
                    st_we     = 1'b1;
                    st_waddr  = grant_idx;
                    st_wdata  = grant_entry;
                    n_fc      = r_fc - 1'b1;
                    if (top_c == r_deep) begin
                        n_deep = r_deep + 1'b1;
                    end
                    n_res.frame = FRAME_W'(grant_idx);
                end else if (!in_range || !st_rdata.alloc) begin
                    n_res.status = ST_ERR;
                end else begin
                    st_waddr = r_frame_idx(r_frame);
                    case (r_func)
                        FN_RELEASE: begin
                            n_res.owner    = st_rdata.owner;
                            n_res.page     = st_rdata.page;
                            st_we          = 1'b1;
                            st_wdata.alloc = 1'b0;
                            st_wdata.lock  = 1'b0;
                            st_wdata.used  = 1'b0;
                            st_wdata.dirty = 1'b0;
                            if (r_fc < FULL_COUNT) begin
                                n_fc  = r_fc + 1'b1;
                                sk_we = 1'b1;
                            end
                        end
                        FN_UNLOCK: begin
                            if (!st_rdata.lock) begin
                                n_res.status = ST_ERR;
                            end else begin
                                st_we         = 1'b1;
                                st_wdata.lock = 1'b0;
                            end
                        end
                        FN_OWNER: begin
                            st_we          = 1'b1;
                            st_wdata.owner = r_owner;
                        end
                        FN_TOUCH: begin
                            st_we          = 1'b1;
                            st_wdata.used  = 1'b1;
                            st_wdata.dirty = st_rdata.dirty | r_wr;
                        end
                        default: begin
                            n_res.status = ST_ERR;
                        end
                    endcase
                end
            end
            S_WALK: begin
                // Read data belongs to r_pos; the next frame is fetched in the same cycle.
                if (!st_rdata.lock && !st_rdata.used) begin
                    n_res.status = ST_EVICT;
                    n_res.frame  = FRAME_W'(r_pos);
                    n_res.owner  = st_rdata.owner;
                    n_res.page   = st_rdata.page;
                    n_res.dirty  = st_rdata.dirty;
                    n_hand       = r_pos;
                    st_we        = 1'b1;
                    st_wdata     = grant_entry;
                    n_state      = S_DONE;
                end else begin
                    if (!st_rdata.lock) begin
                        st_we         = 1'b1;
                        st_wdata.used = 1'b0;
                    end
                    if (r_cnt == LAST_STEP) begin
                        n_res        = '0;
                        n_res.status = ST_BUSY;
                        n_state      = S_DONE;
                    end else begin
                        st_re    = 1'b1;
                        st_raddr = pos_next;
                        n_pos    = pos_next;
                        n_cnt    = r_cnt + 1'b1;
                    end
                end
            end
            S_DONE: begin
                if (!r_o_valid || o_rsp.ready) begin
                    n_o_valid = 1'b1;
                    n_out     = r_res;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_clr     <= '0;
            r_fc      <= FULL_COUNT;
            r_deep    <= '0;
            r_hand    <= LAST_FRAME;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_clr     <= n_clr;
            r_fc      <= n_fc;
            r_deep    <= n_deep;
            r_hand    <= n_hand;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos <= n_pos;
        r_cnt <= n_cnt;
        r_res <= n_res;
        r_out <= n_out;
        if (xfer_in) begin
            r_func  <= i_req.func;
            r_frame <= i_req.frame;
            r_owner <= i_req.owner_id;
            r_page  <= i_req.virtual_page;
            r_wr    <= i_req.is_write;
        end
    end

    `ASSERT_CLKD(a_fc_bound, i_clk, i_rst_n, r_fc <= FULL_COUNT, "free count above frame count")
    `ASSERT_CLKD(a_walk_full, i_clk, i_rst_n, (r_state == S_WALK) |-> (r_fc == '0),
                 "clock walk with free frames left")
    `ASSERT_CLKD(a_ram_rw, i_clk, i_rst_n, (st_we && st_re) |-> (st_waddr != st_raddr),
                 "frame memory read and write collide")
    `ASSERT_CLKD(a_out_src, i_clk, i_rst_n, $rose(o_rsp.valid) |-> $past(r_state == S_DONE),
                 "result raised outside finish state")

endmodule
`default_nettype wire

/* test/testbench.sv */
`default_nettype none
module testbench;
    import fac_pkg::*;

    localparam int FRAMES        = NUM_FRAMES_DEF;
    localparam int RANDOM_ITEMS  = 1550;
    localparam int PHASE_ITEMS   = 250;
    localparam int HOLD_CYCLES   = 400;
    localparam int STUCK_LIMIT   = 5000;
    localparam int SETTLE_CYCLES = 2 * FRAMES + 70;
    localparam int BACKLOG_DEPTH = 4;

    typedef struct packed {
        t_func               func;
        logic [FRAME_W-1:0]  frame;
        logic [OWNER_W-1:0]  owner;
        logic [PAGE_W-1:0]   page;
        logic                wr;
    } frame_req_t;

    typedef struct packed {
        t_status             status;
        logic [FRAME_W-1:0]  frame;
        logic [OWNER_W-1:0]  owner;
        logic [PAGE_W-1:0]   page;
        logic                dirty;
    } frame_rsp_t;

    logic clk;
    logic rst_n;

    fac_req_if req_if();
    fac_rsp_if rsp_if();

    frame_allocator_clock_replace uut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    // Frame table as the block should hold it after every accepted transfer.
    bit                 is_free   [FRAMES];
    bit                 is_locked [FRAMES];
    bit                 is_used   [FRAMES];
    bit                 is_dirty  [FRAMES];
    logic [OWNER_W-1:0] owner_of  [FRAMES];
    logic [PAGE_W-1:0]  page_of   [FRAMES];
    logic [FRAME_W-1:0] free_stack[FRAMES];
    int                 free_left;
    int                 hand;

    frame_req_t req_backlog[$];
    frame_rsp_t replies_owed[$];
    frame_req_t on_wire;

    int send_idle_pct;
    int recv_stall_pct;
    int hold_requests;
    int hold_served;
    int hold_left;
    int stuck_cycles;
    int mismatches;

    always #10 clk = ~clk;

    function automatic void claim_frame(int f, frame_req_t r);
        is_free[f]   = 1'b0;
        is_locked[f] = 1'b1;
        is_used[f]   = 1'b0;
        is_dirty[f]  = 1'b0;
        owner_of[f]  = r.owner;
        page_of[f]   = r.page;
    endfunction

    function automatic frame_rsp_t apply_to_frame_table(frame_req_t r);
        frame_rsp_t o;
        int         f;
        int         pos;
        int         n;
        bit         found;
        o = '0;
        f = r.frame;
        o.status = ST_OK;
        if (r.func == FN_ALLOC) begin
            if (free_left > 0) begin
                pos = free_stack[FRAMES - free_left];
                free_left--;
                claim_frame(pos, r);
                o.frame = FRAME_W'(pos);
            end else begin
                // Second-chance walk: locked frames are skipped, a set use bit
                // is cleared once, and the first clear one is the victim.
                pos = hand;
                found = 1'b0;
                for (n = 0; n < 2 * FRAMES && !found; n++) begin
                    pos = (pos + 1) % FRAMES;
                    if (!is_locked[pos]) begin
                        if (is_used[pos])
                            is_used[pos] = 1'b0;
                        else
                            found = 1'b1;
                    end
                end
                if (found) begin
                    hand    = pos;
                    o.owner = owner_of[pos];
                    o.page  = page_of[pos];
                    o.dirty = is_dirty[pos];
                    claim_frame(pos, r);
                    o.frame  = FRAME_W'(pos);
                    o.status = ST_EVICT;
                end else begin
                    o.status = ST_BUSY;
                end
            end
        end else if (r.func > FN_TOUCH || is_free[f]) begin
            o.status = ST_ERR;
        end else if (r.func == FN_RELEASE) begin
            o.owner      = owner_of[f];
            o.page       = page_of[f];
            is_free[f]   = 1'b1;
            is_locked[f] = 1'b0;
            is_used[f]   = 1'b0;
            is_dirty[f]  = 1'b0;
            if (free_left < FRAMES) begin
                free_left++;
                free_stack[FRAMES - free_left] = FRAME_W'(f);
            end
        end else if (r.func == FN_UNLOCK) begin
            if (!is_locked[f])
                o.status = ST_ERR;
            else
                is_locked[f] = 1'b0;
        end else if (r.func == FN_OWNER) begin
            owner_of[f] = r.owner;
        end else begin
            is_used[f] = 1'b1;
            if (r.wr)
                is_dirty[f] = 1'b1;
        end
        return o;
    endfunction

    // Driver: the payload changes only once the current transfer is done.
    always @(posedge clk) begin
        if (!rst_n) begin
            req_if.valid <= 1'b0;
        end else begin
            if (req_if.valid && req_if.ready)
                replies_owed.push_back(apply_to_frame_table(on_wire));
            if (!req_if.valid || req_if.ready) begin
                if (req_backlog.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    on_wire = req_backlog.pop_front();
                    req_if.valid        <= 1'b1;
                    req_if.func         <= on_wire.func;
                    req_if.frame        <= on_wire.frame;
                    req_if.owner_id     <= on_wire.owner;
                    req_if.virtual_page <= on_wire.page;
                    req_if.is_write     <= on_wire.wr;
                end else begin
                    req_if.valid <= 1'b0;
                end
            end
        end
    end

    task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    task automatic check_reply();
        frame_rsp_t want;
        if (replies_owed.size() == 0) begin
            $error("reply with no request outstanding: status %0d frame %0d",
                   rsp_if.status, rsp_if.result_frame);
            mismatches++;
        end else begin
            want = replies_owed.pop_front();
            compare_field("status", want.status, rsp_if.status);
            compare_field("result_frame", want.frame, rsp_if.result_frame);
            compare_field("old_owner", want.owner, rsp_if.old_owner);
            compare_field("old_page", want.page, rsp_if.old_page);
            compare_field("old_dirty", want.dirty, rsp_if.old_dirty);
        end
    endtask

    // Monitor and receiver back-pressure.
    always @(posedge clk) begin
        if (!rst_n) begin
            rsp_if.ready <= 1'b0;
        end else begin
            if (rsp_if.valid && rsp_if.ready)
                check_reply();
            if (hold_served != hold_requests) begin
                hold_served = hold_requests;
                hold_left   = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                rsp_if.ready <= 1'b0;
            end else begin
                rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n)
            stuck_cycles <= 0;
        else if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
    end

    task automatic send(t_func fn, int frame, int owner, int page, int wr);
        frame_req_t r;
        while (req_backlog.size() >= BACKLOG_DEPTH)
            @(negedge clk);
        r.func  = fn;
        r.frame = FRAME_W'(frame);
        r.owner = OWNER_W'(owner);
        r.page  = PAGE_W'(page);
        r.wr    = 1'(wr);
        req_backlog.push_back(r);
    endtask

    task automatic drain();
        while (req_backlog.size() != 0 || req_if.valid || replies_owed.size() != 0)
            @(negedge clk);
    endtask

    task automatic set_phase(int p);
        case (p)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 54; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 54; end
            default: begin send_idle_pct = 28; recv_stall_pct = 28; end
        endcase
    endtask

    // Random mapped frame, or a locked one; any frame when none qualifies.
    function automatic int pick_frame(bit want_locked);
        int cand[$];
        for (int k = 0; k < FRAMES; k++)
            if (!is_free[k] && (!want_locked || is_locked[k]))
                cand.push_back(k);
        if (cand.size() == 0)
            return $urandom_range(FRAMES - 1);
        return cand[$urandom_range(cand.size() - 1)];
    endfunction

    function automatic int rand_owner();
        return $urandom_range((1 << OWNER_W) - 1);
    endfunction

    function automatic int rand_page();
        return $urandom_range((1 << PAGE_W) - 1);
    endfunction

    task automatic run_stimulus();
        int     r;
        int     n;
        int     a;
        int     b;
        t_func  fn;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        set_phase(0);
        send(FN_ALLOC, 0, 0, 0, 0);
        send(FN_ALLOC, FRAMES - 1, (1 << OWNER_W) - 1, (1 << PAGE_W) - 1, 1);
        send(FN_TOUCH, 0, 0, 0, 1);
        send(FN_TOUCH, 1, 0, 0, 0);
        send(FN_OWNER, 1, 8'hA5, 0, 0);
        send(FN_UNLOCK, 0, 0, 0, 0);
        send(FN_UNLOCK, 0, 0, 0, 0);
        send(FN_RELEASE, 1, 0, 0, 0);
        send(FN_RELEASE, 1, 0, 0, 0);
        send(FN_TOUCH, FRAMES - 1, 0, 0, 1);
        send(FN_UNLOCK, FRAMES - 1, 0, 0, 0);
        send(FN_OWNER, FRAMES - 1, 0, 0, 0);
        for (int k = FN_TOUCH + 1; k < (1 << FUNC_W); k++) begin
            fn = t_func'(k);
            send(fn, FRAMES - 1, (1 << OWNER_W) - 1, (1 << PAGE_W) - 1, 1);
        end
        send(FN_ALLOC, 0, 8'h3C, 16'h1234, 0);
        drain();

        // Use up the free stack, then evict the one unlocked frame and hit
        // the case where every frame is locked.
        n = free_left;
        repeat (n) send(FN_ALLOC, 0, rand_owner(), rand_page(), 0);
        send(FN_ALLOC, 0, rand_owner(), rand_page(), 0);
        send(FN_ALLOC, 0, rand_owner(), rand_page(), 0);
        drain();
        // Two random frames, which may coincide, are unlocked and one of them touched,
        // so the walk gives it a second chance and, if they differ, takes the other first.
        a = $urandom_range(FRAMES - 1);
        b = $urandom_range(FRAMES - 1);
        send(FN_UNLOCK, a, 0, 0, 0);
        send(FN_UNLOCK, b, 0, 0, 0);
        send(FN_TOUCH, a, 0, 0, $urandom_range(1));
        send(FN_ALLOC, 0, rand_owner(), rand_page(), 0);
        send(FN_ALLOC, 0, rand_owner(), rand_page(), 0);
        drain();

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i % PHASE_ITEMS == 0) begin
                drain();
                set_phase((i / PHASE_ITEMS) % 4);
            end
            if (i == 600) begin
                drain();
                send_idle_pct = 0;
                hold_requests++;
            end
            r = $urandom_range(99);
            if (r < 30)
                send(FN_ALLOC, $urandom_range(FRAMES - 1), rand_owner(), rand_page(),
                     $urandom_range(1));
            else if (r < 55)
                send(FN_UNLOCK, pick_frame(1), rand_owner(), rand_page(), $urandom_range(1));
            else if (r < 75)
                send(FN_TOUCH, pick_frame(0), rand_owner(), rand_page(), $urandom_range(1));
            else if (r < 83)
                send(FN_OWNER, pick_frame(0), rand_owner(), rand_page(), $urandom_range(1));
            else if (r < 91)
                send(FN_RELEASE, pick_frame(0), rand_owner(), rand_page(), $urandom_range(1));
            else begin
                fn = t_func'($urandom_range((1 << FUNC_W) - 1));
                send(fn, $urandom_range(FRAMES - 1), rand_owner(), rand_page(),
                     $urandom_range(1));
            end
        end
        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial begin
        clk                 = 1'b0;
        rst_n               = 1'b0;
        req_if.valid        = 1'b0;
        req_if.func         = FN_ALLOC;
        req_if.frame        = '0;
        req_if.owner_id     = '0;
        req_if.virtual_page = '0;
        req_if.is_write     = 1'b0;
        rsp_if.ready        = 1'b0;
        send_idle_pct       = 0;
        recv_stall_pct      = 0;
        hold_requests       = 0;
        hold_served         = 0;
        hold_left           = 0;
        mismatches          = 0;
        free_left           = FRAMES;
        hand                = FRAMES - 1;
        for (int k = 0; k < FRAMES; k++) begin
            is_free[k]    = 1'b1;
            is_locked[k]  = 1'b0;
            is_used[k]    = 1'b0;
            is_dirty[k]   = 1'b0;
            owner_of[k]   = '0;
            page_of[k]    = '0;
            free_stack[k] = FRAME_W'(k);
        end

        fork
            run_stimulus();
            wait (stuck_cycles >= STUCK_LIMIT);
        join_any

        if (stuck_cycles >= STUCK_LIMIT)
            $error("no transfer for %0d cycles, %0d replies outstanding",
                   stuck_cycles, replies_owed.size());
        if (stuck_cycles < STUCK_LIMIT && mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule
`default_nettype wire
